// ===== rtl/sorted_priority_queue_assert.svh =====
// Assertion macros for the sorted priority queue.
// Included by the top level; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SPQ_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication, disabled in reset.
`define SPQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies.
package spq_pkg;

  localparam int DATA_W  = 32;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 5;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  typedef logic signed [DATA_W-1:0] spq_data_t;
  typedef logic [PRIO_W-1:0]        spq_prio_t;

  // Operation broadcast to every cell.
  typedef struct packed {
    logic      push;
    logic      pop;
    spq_data_t data;
    spq_prio_t prio;
  } spq_op_t;

  typedef struct packed {
    spq_status_t        status;
    logic               popped_valid;
    spq_data_t          popped_data;
    spq_prio_t          popped_priority;
    spq_data_t          head_data;
    spq_prio_t          head_priority;
    logic               is_empty;
    logic [COUNT_W-1:0] entry_count;
  } spq_res_t;

endpackage

// ===== rtl/spq_if.sv =====
// Valid/ready channel interfaces for the sorted priority queue.
// Depends on spq_pkg.
interface spq_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  spq_pkg::spq_data_t   data_value;
  spq_pkg::spq_prio_t   priority_req;

  modport source (output valid, mode, data_value, priority_req, input ready);
  modport sink   (input valid, mode, data_value, priority_req, output ready);
endinterface

interface spq_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic                          popped_valid;
  spq_pkg::spq_data_t            popped_data;
  spq_pkg::spq_prio_t            popped_priority;
  spq_pkg::spq_data_t            head_data;
  spq_pkg::spq_prio_t            head_priority;
  logic                          is_empty;
  logic [spq_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, status, popped_valid, popped_data, popped_priority,
                  head_data, head_priority, is_empty, entry_count, input ready);
  modport sink   (input valid, status, popped_valid, popped_data, popped_priority,
                  head_data, head_priority, is_empty, entry_count, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts right on insert, left on pop.
// Depends on spq_pkg.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_op_t   op,
  input  logic               occ,
  input  logic               left_keep,
  input  spq_pkg::spq_data_t left_data,
  input  spq_pkg::spq_prio_t left_prio,
  input  spq_pkg::spq_data_t right_data,
  input  spq_pkg::spq_prio_t right_prio,
  output spq_pkg::spq_data_t data,
  output spq_pkg::spq_prio_t prio,
  output logic               keep
);
  import spq_pkg::*;

  spq_data_t data_r;
  spq_prio_t prio_r;

  // Stays put on insert when it ranks at or above the new entry (ties keep arrival order).
  assign keep = occ && (prio_r >= op.prio);

  always_ff @(posedge clk) begin
    if (op.push && !keep) begin
      if (left_keep) begin
        data_r <= op.data;
        prio_r <= op.prio;
      end else begin
        data_r <= left_data;
        prio_r <= left_prio;
      end
    end else if (op.pop) begin
      data_r <= right_data;
      prio_r <= right_prio;
    end
  end

  assign data = data_r;
  assign prio = prio_r;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: valid/ready in/out channels, no configuration port.
// Each item on in_ch is a push (mode 0: data_value, priority_req) or a pop (mode 1).
// Entries live in a chain of QUEUE_DEPTH cells kept sorted by priority, head in
// cell 0; larger priority leaves first, equal priorities in arrival order.
// On a push every cell compares its priority with the new one in parallel and
// either holds, takes the new entry or takes its left neighbor; on a pop every
// cell takes its right neighbor.
// Each accepted item gives one result on out_ch in the next cycle: status, the
// removed entry on a pop, the head after the operation, empty flag and count.
// A push to a full queue is dropped (status 1); a pop on an empty queue gives
// status 2 and changes nothing.
// Throughput: one item per cycle while out_ch.ready is high; the result
// register frees in the same cycle it is taken. When the receiver stalls,
// the result is held and in_ch.ready drops until it is taken.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; cell contents are not cleared and are never shown while unused.
// Depends on spq_pkg, spq_if, spq_cell and sorted_priority_queue_assert.svh.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic      clk,
  input logic      rst_n,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  spq_res_t      res_r, res_nxt;

  spq_op_t   op;
  spq_data_t cell_data [QUEUE_DEPTH];
  spq_prio_t cell_prio [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;
  logic [QUEUE_DEPTH-1:0] occ;

  logic accept, is_pop, full, empty;
  spq_data_t head_d;
  spq_prio_t head_p;
  logic [CW+COUNT_W-1:0] count_ext;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_pop      = (in_ch.mode == MODE_POP);
  assign full        = (count_r == CW'(QUEUE_DEPTH));
  assign empty       = (count_r == '0);

  assign op.push = accept && !is_pop && !full;
  assign op.pop  = accept && is_pop && !empty;
  assign op.data = in_ch.data_value;
  assign op.prio = in_ch.priority_req;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occ[i] = (count_r > CW'(i));
    if (i == 0) begin : g_first
      spq_cell u_cell (
        .clk       (clk),
        .op        (op),
        .occ       (occ[i]),
        .left_keep (1'b1),
        .left_data (op.data),
        .left_prio (op.prio),
        .right_data(cell_data[i+1]),
        .right_prio(cell_prio[i+1]),
        .data      (cell_data[i]),
        .prio      (cell_prio[i]),
        .keep      (keep[i])
      );
    end else if (i == QUEUE_DEPTH - 1) begin : g_last
      spq_cell u_cell (
        .clk       (clk),
        .op        (op),
        .occ       (occ[i]),
        .left_keep (keep[i-1]),
        .left_data (cell_data[i-1]),
        .left_prio (cell_prio[i-1]),
        .right_data(op.data),
        .right_prio(op.prio),
        .data      (cell_data[i]),
        .prio      (cell_prio[i]),
        .keep      (keep[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk       (clk),
        .op        (op),
        .occ       (occ[i]),
        .left_keep (keep[i-1]),
        .left_data (cell_data[i-1]),
        .left_prio (cell_prio[i-1]),
        .right_data(cell_data[i+1]),
        .right_prio(cell_prio[i+1]),
        .data      (cell_data[i]),
        .prio      (cell_prio[i]),
        .keep      (keep[i])
      );
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (op.push) begin
      count_nxt = count_r + CW'(1);
    end else if (op.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Head after the operation.
  always_comb begin
    head_d = cell_data[0];
    head_p = cell_prio[0];
    if (op.push && !keep[0]) begin
      head_d = op.data;
      head_p = op.prio;
    end else if (op.pop) begin
      head_d = cell_data[1];
      head_p = cell_prio[1];
    end
  end

  assign count_ext = (CW + COUNT_W)'(count_nxt);

  always_comb begin
    res_nxt                 = res_r;
    res_nxt.status          = ST_DONE;
    res_nxt.popped_valid    = op.pop;
    res_nxt.popped_data     = op.pop ? cell_data[0] : '0;
    res_nxt.popped_priority = op.pop ? cell_prio[0] : '0;
    res_nxt.is_empty        = (count_nxt == '0);
    res_nxt.head_data       = res_nxt.is_empty ? '0 : head_d;
    res_nxt.head_priority   = res_nxt.is_empty ? '0 : head_p;
    res_nxt.entry_count     = count_ext[COUNT_W-1:0];
    if (!is_pop && full) begin
      res_nxt.status = ST_FULL;
    end else if (is_pop && empty) begin
      res_nxt.status = ST_EMPTY;
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = res_r.status;
  assign out_ch.popped_valid    = res_r.popped_valid;
  assign out_ch.popped_data     = res_r.popped_data;
  assign out_ch.popped_priority = res_r.popped_priority;
  assign out_ch.head_data       = res_r.head_data;
  assign out_ch.head_priority   = res_r.head_priority;
  assign out_ch.is_empty        = res_r.is_empty;
  assign out_ch.entry_count     = res_r.entry_count;

  `SPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(QUEUE_DEPTH))
  `SPQ_ASSERT_NEXT(a_pop_dec, clk, rst_n, op.pop, count_r == $past(count_r) - CW'(1))
  `SPQ_ASSERT_NEXT(a_accept_result, clk, rst_n, accept, out_valid_r)
  `SPQ_ASSERT_NOW(a_pop_order, clk, rst_n,
    out_valid_r && res_r.popped_valid && !res_r.is_empty,
    res_r.popped_priority >= res_r.head_priority)

endmodule
